>>> rtl/hhc_pkg.sv
// Shared types, constants and the saturating-add helper function of the heater hysteresis controller.
package hhc_pkg;

  // Depth of the sample ring that feeds the running mean.
  localparam int unsigned MEAN_DEPTH = 8;

  localparam int unsigned SAMPLE_W   = 14;
  localparam int unsigned TEMP_W     = 16;
  localparam int unsigned TIME_W     = 16;
  localparam int unsigned TARGET_W   = 15;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned PTR_W = (MEAN_DEPTH > 1) ? $clog2(MEAN_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(MEAN_DEPTH + 1);

  localparam int unsigned HOT_LIMIT_VAL = 9000;
  localparam int unsigned SUM_W = $clog2(MEAN_DEPTH * HOT_LIMIT_VAL + 1);

  localparam logic [TEMP_W-1:0]   HOT_LIMIT     = TEMP_W'(HOT_LIMIT_VAL);
  localparam logic [TIME_W-1:0]   REPORT_GAP_MS = 16'd30000;
  localparam logic [TIME_W-1:0]   NEAR_ON_MAX   = 16'd4000;
  localparam logic [TIME_W-1:0]   NEAR_OFF_MIN  = 16'd5000;
  localparam logic [TIME_W-1:0]   CLOSE_ON_MAX  = 16'd3000;
  localparam logic [TIME_W-1:0]   CLOSE_OFF_MIN = 16'd10000;
  localparam logic [TARGET_W+1:0] MEAN_BAND     = 17'd200;
  localparam logic [TARGET_W+1:0] INSTANT_BAND  = 17'd40;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_DEAD = 2'd1,
    FAULT_HOT  = 2'd2
  } fault_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET = 8'd0,
    REG_ENABLE = 8'd1
  } reg_idx_e;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic             heater;
    logic             pump;
    fault_e           fault;
    logic             report;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } result_t;

  function automatic logic [TIME_W-1:0] sat_add16(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

>>> rtl/hhc_update.sv
// Controller state, sample ring and the per-tick heater decision.
module hhc_update (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  hhc_pkg::cfg_wr_t               cfg_i,
  input  logic                           step_i,
  input  logic signed [hhc_pkg::TEMP_W-1:0] temp_i,
  input  logic [hhc_pkg::TIME_W-1:0]     elapsed_i,
  output hhc_pkg::result_t               result_o
);
  import hhc_pkg::*;

  localparam int unsigned PROD_W = TARGET_W + 2 + CNT_W + 1;

  logic [TARGET_W-1:0] target_q, target_d;
  logic                enable_q, enable_d;
  logic [SAMPLE_W-1:0] ring_q [MEAN_DEPTH];
  logic [PTR_W-1:0]    pos_q, pos_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic                heater_q, heater_d;
  logic                pump_q, pump_d;
  logic [TIME_W-1:0]   on_q, on_d;
  logic [TIME_W-1:0]   off_q, off_d;
  logic                timing_q, timing_d;
  logic [TIME_W-1:0]   since_q, since_d;
  logic                reported_q, reported_d;
  logic [TIME_W-1:0]   gap_q, gap_d;

  fault_e                     fault;
  logic                       report;
  logic [SAMPLE_W-1:0]        old_sample;
  logic [TIME_W-1:0]          dt;
  logic signed [TARGET_W+1:0] tgt_s;
  logic signed [TARGET_W+1:0] temp_s;
  logic signed [CNT_W:0]      cnt_s;
  logic signed [PROD_W-1:0]   sum_s;
  logic signed [PROD_W-1:0]   lo_prod;
  logic signed [PROD_W-1:0]   mid_prod;
  logic                       cfg_hit;

  assign tgt_s  = signed'({2'b00, target_q});
  assign temp_s = signed'({temp_i[TEMP_W-1], temp_i});
  assign cnt_s  = signed'({1'b0, fill_d});
  assign sum_s  = signed'({{(PROD_W - SUM_W){1'b0}}, sum_d});
  assign lo_prod  = PROD_W'(tgt_s - signed'(MEAN_BAND)) * PROD_W'(cnt_s);
  assign mid_prod = PROD_W'(tgt_s) * PROD_W'(cnt_s);

  // Slots are filled in order from zero, so until the ring is full a slot not yet reached counts as zero.
  assign old_sample = (fill_q < CNT_W'(MEAN_DEPTH)) ? '0 : ring_q[pos_q];
  assign dt = sat_add16(gap_q, elapsed_i);

  always_comb begin
    target_d   = target_q;
    enable_d   = enable_q;
    pos_d      = pos_q;
    fill_d     = fill_q;
    sum_d      = sum_q;
    heater_d   = heater_q;
    pump_d     = pump_q;
    on_d       = on_q;
    off_d      = off_q;
    timing_d   = timing_q;
    since_d    = since_q;
    reported_d = reported_q;
    gap_d      = gap_q;
    report     = 1'b0;
    cfg_hit    = 1'b0;

    if (temp_i[TEMP_W-1] || temp_i == '0) begin
      fault = FAULT_DEAD;
    end else if (temp_i > signed'(HOT_LIMIT)) begin
      fault = FAULT_HOT;
    end else begin
      fault = FAULT_NONE;
    end

    if (step_i) begin
      since_d = sat_add16(since_q, elapsed_i);
      if (fault != FAULT_NONE) begin
        heater_d = 1'b0;
        pump_d   = 1'b0;
        if (timing_q) begin
          gap_d = dt;
        end
        if (!reported_q || since_d >= REPORT_GAP_MS) begin
          report     = 1'b1;
          reported_d = 1'b1;
          since_d    = '0;
        end
      end else begin
        sum_d = sum_q - SUM_W'(old_sample) + SUM_W'(temp_i[SAMPLE_W-1:0]);
        pos_d = (pos_q == PTR_W'(MEAN_DEPTH - 1)) ? '0 : pos_q + 1'b1;
        if (fill_q < CNT_W'(MEAN_DEPTH)) begin
          fill_d = fill_q + 1'b1;
        end
        if (target_q == '0 || !enable_q) begin
          heater_d = 1'b0;
          pump_d   = 1'b0;
          on_d     = '0;
          off_d    = '0;
          timing_d = 1'b0;
          gap_d    = '0;
        end else begin
          pump_d = 1'b1;
          if (timing_q) begin
            if (heater_q) begin
              on_d  = sat_add16(on_q, dt);
              off_d = '0;
            end else begin
              off_d = sat_add16(off_q, dt);
              on_d  = '0;
            end
          end
          timing_d = 1'b1;
          gap_d    = '0;

          // Far below the setpoint (by the mean) the heater runs; closer in, the maximum
          // on and minimum off times decide; with the mean at or above it and the sample near it, the heater stops.
          if (sum_s < lo_prod) begin
            heater_d = 1'b1;
          end else if (temp_s < tgt_s - signed'(INSTANT_BAND)) begin
            if (on_d >= NEAR_ON_MAX) begin
              heater_d = 1'b0;
            end else if (off_d >= NEAR_OFF_MIN) begin
              heater_d = 1'b1;
            end
          end else if (sum_s < mid_prod) begin
            if (on_d >= CLOSE_ON_MAX) begin
              heater_d = 1'b0;
            end else if (off_d >= CLOSE_OFF_MIN) begin
              heater_d = 1'b1;
            end
          end else begin
            heater_d = 1'b0;
          end
        end
      end
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_TARGET: begin
          target_d = cfg_i.data[TARGET_W-1:0];
          cfg_hit  = 1'b1;
        end
        REG_ENABLE: begin
          enable_d = cfg_i.data[0];
          cfg_hit  = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
      if (cfg_hit && (target_d == '0 || !enable_d)) begin
        heater_d = 1'b0;
        pump_d   = 1'b0;
        on_d     = '0;
        off_d    = '0;
        timing_d = 1'b0;
        gap_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= '0;
      enable_q   <= 1'b0;
      pos_q      <= '0;
      fill_q     <= '0;
      sum_q      <= '0;
      heater_q   <= 1'b0;
      pump_q     <= 1'b0;
      on_q       <= '0;
      off_q      <= '0;
      timing_q   <= 1'b0;
      since_q    <= '0;
      reported_q <= 1'b0;
      gap_q      <= '0;
    end else begin
      target_q   <= target_d;
      enable_q   <= enable_d;
      pos_q      <= pos_d;
      fill_q     <= fill_d;
      sum_q      <= sum_d;
      heater_q   <= heater_d;
      pump_q     <= pump_d;
      on_q       <= on_d;
      off_q      <= off_d;
      timing_q   <= timing_d;
      since_q    <= since_d;
      reported_q <= reported_d;
      gap_q      <= gap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && fault == FAULT_NONE) begin
      ring_q[pos_q] <= temp_i[SAMPLE_W-1:0];
    end
  end

  assign result_o.heater = heater_d;
  assign result_o.pump   = pump_d;
  assign result_o.fault  = fault;
  assign result_o.report = report;
  assign result_o.sum    = sum_d;
  assign result_o.count  = fill_d;

endmodule

>>> rtl/hhc_mean.sv
// Mean of the stored samples by reciprocal multiplication with a constant table.
module hhc_mean (
  input  logic [hhc_pkg::SUM_W-1:0]    sum_i,
  input  logic [hhc_pkg::CNT_W-1:0]    count_i,
  output logic [hhc_pkg::SAMPLE_W-1:0] mean_o
);
  import hhc_pkg::*;

  // With this shift the rounded-up reciprocal gives the exact floor for
  // every sum that fits in SUM_W bits.
  localparam int unsigned RCP_SHIFT = SUM_W + CNT_W;
  localparam int unsigned RCP_W     = RCP_SHIFT + 1;

  logic [RCP_W-1:0]       rcp_tab [MEAN_DEPTH+1];
  logic [SUM_W+RCP_W-1:0] product;

  assign rcp_tab[0] = '0;
  for (genvar g = 1; g <= MEAN_DEPTH; g++) begin : g_rcp
    localparam longint unsigned RcpVal =
      ((longint'(1) << RCP_SHIFT) + longint'(g) - 1) / longint'(g);
    assign rcp_tab[g] = RCP_W'(RcpVal);
  end

  assign product = (SUM_W + RCP_W)'(sum_i) * (SUM_W + RCP_W)'(rcp_tab[count_i]);
  assign mean_o  = product[RCP_SHIFT +: SAMPLE_W];

endmodule

>>> rtl/heater_hysteresis_controller_core.sv
// Top level of the heater hysteresis controller: channels and the three-stage item pipeline.
//
// Each input item is one evaluation tick: a signed temperature in 0.01 degree
// units and the milliseconds since the previous tick. Every item gives exactly
// one result item with heater and pump drive, fault code, fault report strobe
// and the mean of the stored samples.
// The configuration channel writes the setpoint (index 0) and the enable bit
// (index 1); it is ready whenever the input register is empty, and writes are
// expected only while no item is in flight. Other indexes are ignored.
// An accepted item waits in the input register, the controller state and
// heater decision are updated as it moves to the middle stage, and the mean
// is formed by a reciprocal multiply on its way to the output register. One
// item per cycle is sustained while the receiver takes results.
// When the receiver stalls, the stages fill up and tready drops only once all
// three hold items; a stalled result holds still.
// Reset clears all control state, the setpoint and enable, the fill count and
// the running sum; the sample ring needs no clearing since the fill count tells
// which slots hold samples.
module heater_hysteresis_controller_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [hhc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [hhc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Tick input: [15:0] temp_sample (signed), [31:16] elapsed_ms.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,
  // Result: [0] heater_on, [1] pump_on, [3:2] fault_code, [4] fault_report,
  // [18:5] mean_temp, [23:19] zero.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [23:0]                       m_axis_tdata
);
  import hhc_pkg::*;

  logic va_q, vb_q, vc_q;
  logic adv_a, adv_b, adv_c;

  logic signed [TEMP_W-1:0] temp_q;
  logic [TIME_W-1:0]        elapsed_q;
  result_t                  upd_res;
  result_t                  res_q;
  cfg_wr_t                  cfg_wr;
  logic [SAMPLE_W-1:0]      mean;

  logic                heater_q, pump_q, report_q;
  fault_e              fault_q;
  logic [SAMPLE_W-1:0] mean_q;

  // Each stage moves on when the one after it is empty or moving.
  assign adv_c = !vc_q || m_axis_tready;
  assign adv_b = !vb_q || adv_c;
  assign adv_a = !va_q || adv_b;

  assign s_axis_tready = adv_a;
  // A write never lands in the same cycle as a state update of an item.
  assign cfg_ready_o   = !va_q;

  assign cfg_wr.valid = cfg_valid_i && !va_q;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  hhc_update u_update (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_wr),
    .step_i    (va_q && adv_b),
    .temp_i    (temp_q),
    .elapsed_i (elapsed_q),
    .result_o  (upd_res)
  );

  hhc_mean u_mean (
    .sum_i   (res_q.sum),
    .count_i (res_q.count),
    .mean_o  (mean)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (adv_a) begin
        va_q <= s_axis_tvalid;
      end
      if (adv_b) begin
        vb_q <= va_q;
      end
      if (adv_c) begin
        vc_q <= vb_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && adv_a) begin
      temp_q    <= signed'(s_axis_tdata[15:0]);
      elapsed_q <= s_axis_tdata[31:16];
    end
    if (va_q && adv_b) begin
      res_q <= upd_res;
    end
    if (vb_q && adv_c) begin
      heater_q <= res_q.heater;
      pump_q   <= res_q.pump;
      fault_q  <= res_q.fault;
      report_q <= res_q.report;
      mean_q   <= mean;
    end
  end

  assign m_axis_tvalid = vc_q;
  assign m_axis_tdata  = {5'b00000, mean_q, report_q, fault_q, pump_q, heater_q};

endmodule

>>> rtl/hhc_checker.sv
// Port-level checks of the heater hysteresis controller and their bind.
module hhc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_tvalid_i,
  input logic        m_tready_i,
  input logic [23:0] m_tdata_i
);
  import hhc_pkg::*;

  // A stalled result holds its value.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("result changed while stalled");

  // The heater never runs without the pump.
  a_heater_pump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tdata_i[0] |-> m_tdata_i[1])
    else $error("heater on with pump off");

  // A faulted tick drives heater and pump off.
  a_fault_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tdata_i[3:2] != FAULT_NONE |-> m_tdata_i[1:0] == 2'b00)
    else $error("drive active during fault");

  // A report strobe comes only with a fault.
  a_report_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tdata_i[4] |-> m_tdata_i[3:2] != FAULT_NONE)
    else $error("report without fault");

  // The mean of good samples never exceeds the hot limit.
  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> m_tdata_i[18:5] <= HOT_LIMIT[SAMPLE_W-1:0])
    else $error("mean out of range");

endmodule

bind heater_hysteresis_controller_core hhc_checker u_hhc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready),
  .m_tdata_i  (m_axis_tdata)
);
